### sv/utf8u16_pkg.sv
// Package for the UTF-8 to UTF-16 transcoder: payload structs, the burst
// descriptor passed from the front end to the unit emitter, and byte classes.
// Depends on nothing.
package utf8u16_pkg;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_in_run;
        logic        text_done;
    } unit_item_t;

    // One burst: repl_count '?' units, then value_count units (hi, then lo).
    typedef struct packed {
        logic [2:0]  repl_count;
        logic [1:0]  value_count;
        logic [15:0] unit_hi;
        logic [15:0] unit_lo;
        logic        eot;
    } burst_t;

    typedef enum logic [2:0] {
        CLS_CONT,
        CLS_SINGLE,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_INVALID
    } byte_class_t;

    localparam logic [15:0] UNIT_REPLACE = 16'h003F;
    localparam logic [15:0] SURR_HI_BASE = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // Class of a byte from its top five bits.
    function automatic byte_class_t classify(input logic [7:0] b);
        byte_class_t c;
        if (b[7] == 1'b0) begin
            c = CLS_SINGLE;
        end
        else if (b[6] == 1'b0) begin
            c = CLS_CONT;
        end
        else if (b[5] == 1'b0) begin
            c = CLS_LEAD2;
        end
        else if (b[4] == 1'b0) begin
            c = CLS_LEAD3;
        end
        else if (b[3] == 1'b0) begin
            c = CLS_LEAD4;
        end
        else begin
            c = CLS_INVALID;
        end
        return c;
    endfunction

endpackage

### sv/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder, top level. Depends on utf8u16_pkg,
// utf8u16_front, utf8u16_queue and utf8u16_back.
//
// One UTF-8 byte is taken per transfer on the input queue interface (push and
// full) and the resulting UTF-16 code units leave one per transfer on the
// output queue interface (empty and pop). A byte is accepted every cycle as
// long as the descriptor queue has room. Each byte that completes a code
// point, or that causes replacements, becomes one descriptor; the emitter
// drains a descriptor at one unit per cycle while the output is popped, and
// a descriptor holds 1 to 4 units. The sustained rate is thus one byte per
// cycle for text of one-unit characters, and one unit per cycle overall,
// set by the single output register of the emitter. Bytes that only extend
// a pending sequence yield no units and cost the emitter nothing. The
// QUEUE_DEPTH descriptors of buffering absorb bursts of replacements and
// surrogate pairs. Replacements are 0x003F; the final unit caused by a byte
// carries last_in_run, and if that byte carried end_of_text the unit also
// carries text_done. No overlong or surrogate range checks are made.
module utf8_to_utf16_transcoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  utf8u16_pkg::byte_item_t byte_item,
    output logic                    empty,
    input  logic                    pop,
    output utf8u16_pkg::unit_item_t unit_item
);

    logic                accept;
    logic                burst_valid;
    utf8u16_pkg::burst_t burst_in;
    utf8u16_pkg::burst_t burst_head;
    logic                burst_empty;
    logic                burst_pop;

    // A byte transfer needs only a free descriptor slot.
    assign accept = push && !full;

    utf8u16_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (byte_item),
        .burst_valid (burst_valid),
        .burst       (burst_in)
    );

    utf8u16_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (burst_valid),
        .wr_data (burst_in),
        .rd_en   (burst_pop),
        .rd_data (burst_head),
        .full    (full),
        .empty   (burst_empty)
    );

    utf8u16_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst_head),
        .burst_empty (burst_empty),
        .burst_pop   (burst_pop),
        .empty       (empty),
        .pop         (pop),
        .unit_item   (unit_item)
    );

endmodule

### sv/utf8u16_front.sv
// Front end of the transcoder: classifies each byte, tracks the pending
// sequence and produces one burst descriptor per byte that yields units.
// Depends on utf8u16_pkg.
module utf8u16_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  utf8u16_pkg::byte_item_t item,
    output logic                   burst_valid,
    output utf8u16_pkg::burst_t    burst
);

    logic [7:0] held_bytes_reg [3];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] needed_reg;
    logic [2:0] needed_next;

    logic       hold_we;
    logic [1:0] hold_idx;
    logic [20:0] cp;
    logic [20:0] v;
    logic [2:0]  repl;
    logic [1:0]  vcnt;
    logic [15:0] hi;
    logic [15:0] lo;
    utf8u16_pkg::byte_class_t cls;

    assign cls = utf8u16_pkg::classify(item.text_byte);
    assign v   = cp - utf8u16_pkg::SUPP_BASE;

    // Code point assembly from the held lead and continuations.
    always_comb
    begin
        unique case (needed_reg)
            3'd2:    cp = {10'd0, held_bytes_reg[0][4:0], item.text_byte[5:0]};
            3'd3:    cp = {5'd0, held_bytes_reg[0][3:0], held_bytes_reg[1][5:0],
                           item.text_byte[5:0]};
            default: cp = {held_bytes_reg[0][2:0], held_bytes_reg[1][5:0],
                           held_bytes_reg[2][5:0], item.text_byte[5:0]};
        endcase
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        needed_next     = needed_reg;
        hold_we         = 1'b0;
        hold_idx        = held_count_reg;
        repl            = 3'd0;
        vcnt            = 2'd0;
        hi              = 16'd0;
        lo              = 16'd0;
        if (held_count_reg != 2'd0 && cls == utf8u16_pkg::CLS_CONT) begin
            if ({1'b0, held_count_reg} + 3'd1 == needed_reg) begin
                held_count_next = 2'd0;
                needed_next     = 3'd0;
                if (cp < utf8u16_pkg::SUPP_BASE) begin
                    vcnt = 2'd1;
                    hi   = cp[15:0];
                end
                else begin
                    vcnt = 2'd2;
                    hi   = utf8u16_pkg::SURR_HI_BASE + {5'd0, v[20:10]};
                    lo   = utf8u16_pkg::SURR_LO_BASE + {6'd0, v[9:0]};
                end
            end
            else if (held_count_reg != 2'd3) begin
                hold_we         = 1'b1;
                held_count_next = held_count_reg + 2'd1;
            end
        end
        else begin
            // Any pending bytes become replacements, then the byte starts anew: a single, a lead, or a replacement.
            repl            = {1'b0, held_count_reg};
            held_count_next = 2'd0;
            needed_next     = 3'd0;
            unique case (cls)
                utf8u16_pkg::CLS_SINGLE:
                begin
                    vcnt = 2'd1;
                    hi   = {8'd0, item.text_byte};
                end
                utf8u16_pkg::CLS_LEAD2, utf8u16_pkg::CLS_LEAD3, utf8u16_pkg::CLS_LEAD4:
                begin
                    hold_we         = 1'b1;
                    hold_idx        = 2'd0;
                    held_count_next = 2'd1;
                    needed_next     = (cls == utf8u16_pkg::CLS_LEAD2) ? 3'd2 :
                                      (cls == utf8u16_pkg::CLS_LEAD3) ? 3'd3 : 3'd4;
                end
                default:
                begin
                    repl = repl + 3'd1;
                end
            endcase
        end
        // An early end flushes whatever is still pending.
        if (item.end_of_text && held_count_next != 2'd0) begin
            repl            = repl + {1'b0, held_count_next};
            held_count_next = 2'd0;
            needed_next     = 3'd0;
        end
    end

    assign burst_valid       = accept && (repl != 3'd0 || vcnt != 2'd0);
    assign burst.repl_count  = repl;
    assign burst.value_count = vcnt;
    assign burst.unit_hi     = hi;
    assign burst.unit_lo     = lo;
    assign burst.eot         = item.end_of_text;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_count_reg <= 2'd0;
            needed_reg     <= 3'd0;
        end
        else if (accept) begin
            held_count_reg <= held_count_next;
            needed_reg     <= needed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_we) begin
            held_bytes_reg[hold_idx] <= item.text_byte;
        end
    end

endmodule

### sv/utf8u16_queue.sv
// Short queue of burst descriptors between the front end and the emitter.
// Depends on utf8u16_pkg.
module utf8u16_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  utf8u16_pkg::burst_t wr_data,
    input  logic                rd_en,
    output utf8u16_pkg::burst_t rd_data,
    output logic                full,
    output logic                empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    utf8u16_pkg::burst_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/utf8u16_back.sv
// Unit emitter: expands each burst descriptor into UTF-16 units, one per
// cycle while popped, into the output register. Depends on utf8u16_pkg.
module utf8u16_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  utf8u16_pkg::burst_t     burst,
    input  logic                    burst_empty,
    output logic                    burst_pop,
    output logic                    empty,
    input  logic                    pop,
    output utf8u16_pkg::unit_item_t unit_item
);

    logic [1:0] k_reg;
    logic [1:0] k_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    utf8u16_pkg::unit_item_t out_reg;
    utf8u16_pkg::unit_item_t out_next;

    logic       load;
    logic       last;
    logic [2:0] total;
    logic [2:0] kx;
    logic [2:0] vidx;

    assign total = burst.repl_count + {1'b0, burst.value_count};
    assign kx    = {1'b0, k_reg};
    assign vidx  = kx - burst.repl_count;
    assign last  = (kx + 3'd1 == total);
    assign load  = (!out_valid_reg || pop) && !burst_empty;
    assign burst_pop = load && last;

    always_comb
    begin
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (load) begin
            out_valid_next = 1'b1;
            k_next         = last ? 2'd0 : k_reg + 2'd1;
            if (kx < burst.repl_count) begin
                out_next.code_unit = utf8u16_pkg::UNIT_REPLACE;
            end
            else if (vidx == 3'd0) begin
                out_next.code_unit = burst.unit_hi;
            end
            else begin
                out_next.code_unit = burst.unit_lo;
            end
            out_next.last_in_run = last;
            out_next.text_done   = last && burst.eot;
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    assign empty     = !out_valid_reg;
    assign unit_item = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            k_reg         <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
